[src/mit_pkg.sv]
package mit_pkg;

  localparam int OP_W  = 3;
  localparam int CH_W  = 4;
  localparam int VAL_W = 32;
  localparam int CNT_W = 32;

  // Channels the channel field can address at all.
  localparam int MAX_ADDR_CH = 1 << CH_W;

  typedef enum logic [OP_W-1:0] {
    OP_TICK    = 3'd0,
    OP_CLEAR   = 3'd1,
    OP_RESTART = 3'd2,
    OP_SET     = 3'd3,
    OP_POLL    = 3'd4
  } op_e;

  typedef enum logic {
    ST_EMPTY = 1'b0,
    ST_FULL  = 1'b1
  } ctrl_state_e;

  // Command from the controller to the datapath.
  typedef struct packed {
    logic exec;
  } dp_cmd_t;

endpackage

[src/mit_ctrl.sv]
module mit_ctrl
  import mit_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  output logic    in_stall_o,
  output logic    out_valid_o,
  input  logic    out_stall_i,
  output dp_cmd_t cmd_o
);

  ctrl_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_EMPTY;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    in_stall_o  = 1'b0;
    out_valid_o = 1'b0;
    cmd_o       = '0;
    unique case (state_q)
      ST_EMPTY: begin
        cmd_o.exec = in_valid_i;
        if (in_valid_i) begin
          state_d = ST_FULL;
        end
      end
      ST_FULL: begin
        out_valid_o = 1'b1;
        in_stall_o  = out_stall_i;
        cmd_o.exec  = in_valid_i && !out_stall_i;
        if (!out_stall_i && !in_valid_i) begin
          state_d = ST_EMPTY;
        end
      end
      default: begin
        state_d = ST_EMPTY;
      end
    endcase
  end

endmodule

[src/mit_dp.sv]
module mit_dp
  import mit_pkg::*;
#(
  parameter int CHANNELS = 16
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  dp_cmd_t          cmd_i,
  input  logic [OP_W-1:0]  op_i,
  input  logic [CH_W-1:0]  channel_i,
  input  logic [VAL_W-1:0] value_i,
  output logic             expired_o
);

  // Only channels the index field can reach need storage.
  localparam int DEPTH = (CHANNELS < MAX_ADDR_CH) ? CHANNELS : MAX_ADDR_CH;
  localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [CNT_W-1:0] tick_q, tick_d;
  logic [CNT_W-1:0] start_q [DEPTH];
  logic [DEPTH-1:0] pend_q;
  logic             expired_q, expired_d;

  logic [IDX_W-1:0] idx;
  logic             ch_ok;
  logic [CNT_W-1:0] s_eff, e_val;
  logic             hit;
  logic             wr_start, set_pend, clr_pend;
  logic [CNT_W-1:0] wr_data;

  assign idx   = channel_i[IDX_W-1:0];
  assign ch_ok = (int'(channel_i) < CHANNELS);

  // Expiry test on the effective start; a pending channel starts from the count.
  assign s_eff = pend_q[idx] ? tick_q : start_q[idx];
  assign e_val = s_eff + value_i;
  assign hit   = (s_eff < e_val) ? (tick_q >= e_val)
                                 : ((tick_q < s_eff) && (tick_q > e_val));

  always_comb begin
    tick_d    = tick_q;
    expired_d = 1'b0;
    wr_start  = 1'b0;
    wr_data   = tick_q;
    set_pend  = 1'b0;
    clr_pend  = 1'b0;
    unique case (op_e'(op_i))
      OP_TICK: begin
        tick_d = tick_q + CNT_W'(1);
      end
      OP_CLEAR: begin
        set_pend = ch_ok;
      end
      OP_RESTART: begin
        wr_start = ch_ok;
      end
      OP_SET: begin
        wr_start = ch_ok;
        wr_data  = value_i;
      end
      OP_POLL: begin
        clr_pend  = ch_ok && pend_q[idx];
        expired_d = ch_ok && hit;
        wr_start  = ch_ok && (pend_q[idx] || hit);
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tick_q    <= '0;
      pend_q    <= '0;
      expired_q <= 1'b0;
      for (int i = 0; i < DEPTH; i++) begin
        start_q[i] <= '0;
      end
    end else if (cmd_i.exec) begin
      tick_q    <= tick_d;
      expired_q <= expired_d;
      if (wr_start) begin
        start_q[idx] <= wr_data;
      end
      if (set_pend) begin
        pend_q[idx] <= 1'b1;
      end else if (clr_pend) begin
        pend_q[idx] <= 1'b0;
      end
    end
  end

  assign expired_o = expired_q;

endmodule

[src/multichannel_interval_timer.sv]
// Multichannel interval timer. A 32-bit tick counter, advanced by tick operations
// and wrapping around, is shared by CHANNELS channels that each keep a start
// time and a restart-pending flag. Each input transaction carries one operation
// (tick, clear, restart, set start or poll) and produces exactly one output
// transaction whose expired bit is set only when a poll finds its interval
// elapsed; an expired poll restarts the channel at the current count. A poll
// with an interval of zero never expires. Channel numbers at or above CHANNELS
// and unused operation codes change nothing and report zero. Every operation
// runs in the cycle it is accepted: the counter, the start times and the pending
// flags live in flip-flops, so the read, the single 32-bit add and the four
// compares of a poll sit in one register-to-register path. The result is held
// in an output register, so a new transaction is taken every cycle while the
// output side keeps up, and also in the cycle the held result is taken. Reset
// clears the counter, all start times and all pending flags at once.
module multichannel_interval_timer
  import mit_pkg::*;
#(
  parameter int CHANNELS = 16
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  logic [OP_W-1:0]  op_i,
  input  logic [CH_W-1:0]  channel_i,
  input  logic [VAL_W-1:0] value_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output logic             expired_o
);

  dp_cmd_t cmd;

  // The controller tracks whether the output register holds a result and
  // decides when an input transaction may be executed.
  mit_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .cmd_o       (cmd)
  );

  // The datapath holds all timer state and the result register.
  mit_dp #(
    .CHANNELS (CHANNELS)
  ) u_dp (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cmd_i     (cmd),
    .op_i      (op_i),
    .channel_i (channel_i),
    .value_i   (value_i),
    .expired_o (expired_o)
  );

  // An executed transaction always leaves a result waiting.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.exec |=> out_valid_o)
    else $error("executed transaction produced no result");

  // Execution happens exactly when an input transaction is accepted.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.exec == (in_valid_i && !in_stall_o))
    else $error("execute command out of step with input handshake");

  // Only a poll can report an expired interval.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd.exec && (op_i != OP_POLL)) |=> !expired_o)
    else $error("non-poll operation reported expiry");

  // The input side is stalled only while a held result is not taken.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (out_valid_o && out_stall_i))
    else $error("input stalled without a blocked result");

endmodule

[dv/tb_multichannel_interval_timer.sv]
// Self-checking testbench for the multichannel interval timer.
//
// A short directed table runs first and walks the corner cases: polls right
// after reset, an interval of zero, the largest interval, unused operation
// codes, a start time near the top of the 32-bit range so that the deadline
// wraps around, and a clear that re-arms a channel before its next poll.
// After the table, a long random run uses mostly ticks and polls with short
// intervals, so that channels really expire and restart.
//
// A behavioral copy of the timer runs alongside the block. It is updated at
// every accepted input transaction and queues the expired bit that it
// expects. The output monitor compares each accepted output transaction with
// the oldest queued value.
module tb_multichannel_interval_timer
  import mit_pkg::*;
;

  localparam int NUM_CHANNELS = 16;
  localparam int RANDOM_ITEMS = 650;
  localparam int QUIET_LIMIT  = 2000;
  localparam int LONG_HOLD    = 80;
  localparam int DRAIN_SLACK  = 4;
  localparam int NUM_ROWS     = 22;

  // Operation codes that the block must ignore.
  localparam logic [OP_W-1:0] OP_SPARE_A = 3'd5;
  localparam logic [OP_W-1:0] OP_SPARE_B = 3'd6;
  localparam logic [OP_W-1:0] OP_SPARE_C = 3'd7;

  localparam logic [VAL_W-1:0] VAL_ALL_ONES = {VAL_W{1'b1}};

  logic             clk_i       = 1'b0;
  logic             rst_ni      = 1'b0;
  logic             in_valid_i  = 1'b0;
  logic             in_stall_o;
  logic [OP_W-1:0]  op_i        = OP_TICK;
  logic [CH_W-1:0]  channel_i   = '0;
  logic [VAL_W-1:0] value_i     = '0;
  logic             out_valid_o;
  logic             out_stall_i = 1'b0;
  logic             expired_o;

  multichannel_interval_timer #(
    .CHANNELS(NUM_CHANNELS)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .op_i       (op_i),
    .channel_i  (channel_i),
    .value_i    (value_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .expired_o  (expired_o)
  );

  always #10 clk_i = ~clk_i;

  // One row of the directed table. When known is set, want is the expired
  // bit that can be read straight off the row; otherwise the timer copy
  // supplies the expectation.
  typedef struct packed {
    logic [OP_W-1:0]  op;
    logic [CH_W-1:0]  ch;
    logic [VAL_W-1:0] val;
    logic             known;
    logic             want;
  } timer_row_t;

  timer_row_t plan [NUM_ROWS] = '{
    // Right after reset: every start time is zero and the count is zero.
    '{OP_POLL,    4'd0,  32'd0,         1'b1, 1'b0}, // zero interval never expires
    '{OP_POLL,    4'd15, VAL_ALL_ONES,  1'b1, 1'b0}, // largest interval, count too low
    '{OP_SPARE_A, 4'd3,  VAL_ALL_ONES,  1'b1, 1'b0},
    '{OP_SPARE_B, 4'd12, 32'hAAAA_AAAA, 1'b1, 1'b0},
    '{OP_SPARE_C, 4'd5,  32'h5555_5555, 1'b1, 1'b0},
    '{OP_TICK,    4'd0,  32'd0,         1'b1, 1'b0},
    // Count is now one: a one-tick interval from zero has just elapsed.
    '{OP_POLL,    4'd1,  32'd1,         1'b0, 1'b0},
    '{OP_POLL,    4'd1,  32'd1,         1'b0, 1'b0}, // restarted, not yet again
    '{OP_SET,     4'd2,  VAL_ALL_ONES,  1'b1, 1'b0},
    '{OP_POLL,    4'd2,  32'd1,         1'b0, 1'b0}, // deadline wraps to zero
    '{OP_CLEAR,   4'd3,  32'd0,         1'b1, 1'b0},
    '{OP_TICK,    4'd9,  VAL_ALL_ONES,  1'b1, 1'b0}, // value ignored on a tick
    '{OP_POLL,    4'd3,  32'd0,         1'b0, 1'b0}, // re-armed by the clear
    '{OP_RESTART, 4'd4,  32'd0,         1'b1, 1'b0},
    '{OP_POLL,    4'd4,  32'd0,         1'b1, 1'b0},
    '{OP_SET,     4'd5,  32'h8000_0000, 1'b1, 1'b0},
    '{OP_POLL,    4'd5,  32'h7FFF_FFFF, 1'b0, 1'b0}, // deadline at the top, no wrap
    '{OP_POLL,    4'd5,  32'h8000_0000, 1'b0, 1'b0}, // deadline wraps to zero
    '{OP_CLEAR,   4'd15, 32'd0,         1'b1, 1'b0},
    '{OP_POLL,    4'd15, VAL_ALL_ONES,  1'b0, 1'b0},
    '{OP_TICK,    4'd6,  32'd0,         1'b1, 1'b0},
    '{OP_POLL,    4'd15, 32'd1,         1'b0, 1'b0}
  };

  // State of the timer copy.
  logic [CNT_W-1:0] tick_now;
  logic [CNT_W-1:0] start_at [NUM_CHANNELS];
  logic             rearm    [NUM_CHANNELS];

  // Expired bits still owed by the block, oldest first.
  logic expired_q [$];

  int  mismatches   = 0;
  int  quiet_cycles = 0;
  bit  hold_req     = 1'b0;

  initial begin
    tick_now = '0;
    foreach (start_at[i]) begin
      start_at[i] = '0;
      rearm[i]    = 1'b0;
    end
  end

  // Applies one transaction to the timer copy and returns the expired bit.
  function automatic logic timer_apply(logic [OP_W-1:0] op, logic [CH_W-1:0] ch,
                                       logic [VAL_W-1:0] val);
    logic [CNT_W-1:0] base;
    logic [CNT_W-1:0] deadline;
    logic             hit;
    hit = 1'b0;
    if (op == OP_TICK) begin
      tick_now = tick_now + CNT_W'(1);
    end else if (int'(ch) < NUM_CHANNELS) begin
      case (op)
        OP_CLEAR:   rearm[ch] = 1'b1;
        OP_RESTART: start_at[ch] = tick_now;
        OP_SET:     start_at[ch] = val;
        OP_POLL: begin
          // A pending clear restarts the channel before the test.
          if (rearm[ch]) begin
            rearm[ch]    = 1'b0;
            start_at[ch] = tick_now;
          end
          base     = start_at[ch];
          deadline = base + val;
          // Without a wrap the deadline is simply reached; with one, the
          // count must have wrapped below the start but passed the deadline.
          if (base < deadline) begin
            hit = (tick_now >= deadline);
          end else begin
            hit = (tick_now < base) && (tick_now > deadline);
          end
          if (hit) begin
            start_at[ch] = tick_now;
          end
        end
        default: ;
      endcase
    end
    return hit;
  endfunction

  // Offers one transaction and holds it until accepted. It is called just
  // after a rising edge and returns just after the edge of acceptance.
  task automatic send_txn(logic [OP_W-1:0] op, logic [CH_W-1:0] ch,
                          logic [VAL_W-1:0] val, logic known, logic want);
    logic predicted;
    in_valid_i <= 1'b1;
    op_i       <= op;
    channel_i  <= ch;
    value_i    <= val;
    do @(posedge clk_i); while (in_stall_o);
    predicted = timer_apply(op, ch, val);
    expired_q.push_back(known ? want : predicted);
  endtask

  task automatic idle_cycles(int n);
    in_valid_i <= 1'b0;
    repeat (n) @(posedge clk_i);
  endtask

  // Sender: directed table, a full drain, then bursts of random transactions.
  initial begin
    int               issued;
    int               burst;
    int               gap;
    int               r;
    bit               drained_mid;
    logic [OP_W-1:0]  op;
    logic [CH_W-1:0]  ch;
    logic [VAL_W-1:0] val;

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (plan[i]) begin
      send_txn(plan[i].op, plan[i].ch, plan[i].val, plan[i].known, plan[i].want);
      if ($urandom_range(0, 3) == 0) begin
        idle_cycles($urandom_range(1, 3));
      end
    end

    // Let everything from the table come out before the random part.
    idle_cycles(1);
    while (expired_q.size() != 0) @(posedge clk_i);

    issued      = 0;
    drained_mid = 1'b0;
    while (issued < RANDOM_ITEMS) begin
      burst = $urandom_range(1, 24);
      repeat (burst) begin
        r   = $urandom_range(0, 99);
        val = $urandom();
        if ($urandom_range(0, 1) == 0) begin
          ch = CH_W'($urandom_range(0, 3));
        end else begin
          ch = CH_W'($urandom_range(0, NUM_CHANNELS - 1));
        end
        if (r < 35) begin
          op = OP_TICK;
        end else if (r < 43) begin
          op = OP_CLEAR;
        end else if (r < 51) begin
          op = OP_RESTART;
        end else if (r < 63) begin
          // Start times often near the count, so that polls land on both sides
          // of the deadline, some near the top of the range, the rest random.
          op = OP_SET;
          case ($urandom_range(0, 4))
            0: val = tick_now - $urandom_range(0, 8);
            1: val = tick_now + $urandom_range(1, 8);
            2: val = VAL_ALL_ONES - $urandom_range(0, 3);
            default: ;
          endcase
        end else if (r < 97) begin
          op = OP_POLL;
          case ($urandom_range(0, 9))
            0: val = '0;
            1: ;
            2: val = '0 - $urandom_range(1, 16);
            default: val = $urandom_range(1, 12);
          endcase
        end else begin
          case ($urandom_range(0, 2))
            0: op = OP_SPARE_A;
            1: op = OP_SPARE_B;
            default: op = OP_SPARE_C;
          endcase
        end
        send_txn(op, ch, val, 1'b0, 1'b0);
        if (op <= OP_POLL) begin
          issued++;
        end
        // The receiver picks this up and holds off for a long stretch while
        // the bursts keep coming, so the block fills and stalls its input.
        if (issued == 120) begin
          hold_req = 1'b1;
        end
        if (issued >= RANDOM_ITEMS / 2 && !drained_mid) begin
          drained_mid = 1'b1;
          idle_cycles(1);
          while (expired_q.size() != 0) @(posedge clk_i);
        end
      end
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap != 0) begin
        idle_cycles(gap);
      end
    end

    idle_cycles(1);
    while (expired_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_SLACK) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  // Receiver: segments of differing stall patterns, including stretches
  // without any stall, plus one long hold-off when the sender asks for it.
  initial begin
    int seg;
    int mode;
    int k;
    bit held;
    held = 1'b0;
    k    = 0;
    @(posedge rst_ni);
    forever begin
      if (hold_req && !held) begin
        held = 1'b1;
        out_stall_i <= 1'b1;
        repeat (LONG_HOLD) @(posedge clk_i);
      end
      mode = $urandom_range(0, 3);
      seg  = $urandom_range(5, 40);
      repeat (seg) begin
        case (mode)
          0: out_stall_i <= 1'b0;
          1: out_stall_i <= 1'($urandom_range(0, 1));
          2: out_stall_i <= (k % 4 != 0);
          default: out_stall_i <= ($urandom_range(0, 4) == 0);
        endcase
        k++;
        @(posedge clk_i);
      end
    end
  end

  // Output monitor: every accepted output transaction must match the oldest
  // expectation.
  always @(posedge clk_i) begin
    logic oldest;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expired_q.size() == 0) begin
        $error("expired: no transaction expected, actual %0b", expired_o);
        mismatches++;
      end else begin
        oldest = expired_q.pop_front();
        if (expired_o !== oldest) begin
          $error("expired mismatch: expected %0b, actual %0b", oldest, expired_o);
          mismatches++;
        end
      end
    end
  end

  // Watchdog: ends the run if neither side moves for too long.
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("simulation failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

endmodule
